### src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh - shared concurrent assertion macros
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### src/cpt_pkg.sv
// ---------------------------------------------------------------------------
// cpt_pkg - color palette table shared codes
// Command, status and slot constants used by the core and its checker.
// ---------------------------------------------------------------------------
package cpt_pkg;

  localparam int unsigned CmdW    = 3;
  localparam int unsigned ColorW  = 32;
  localparam int unsigned SlotW   = 8;
  localparam int unsigned StatusW = 3;

  // Command codes
  localparam logic [CmdW-1:0] CMD_INTERN = 3'd0;
  localparam logic [CmdW-1:0] CMD_ADD    = 3'd1;
  localparam logic [CmdW-1:0] CMD_FIND   = 3'd2;
  localparam logic [CmdW-1:0] CMD_SET    = 3'd3;
  localparam logic [CmdW-1:0] CMD_REMOVE = 3'd4;

  // Status codes
  localparam logic [StatusW-1:0] ST_OK        = 3'd0;
  localparam logic [StatusW-1:0] ST_FULL      = 3'd1;
  localparam logic [StatusW-1:0] ST_BAD_SLOT  = 3'd2;
  localparam logic [StatusW-1:0] ST_LAST      = 3'd3;
  localparam logic [StatusW-1:0] ST_NOT_FOUND = 3'd4;

  // Slot id reported when there is no slot
  localparam logic [SlotW-1:0] NO_SLOT = 8'd255;

endpackage

### src/color_palette_table_core.sv
// ---------------------------------------------------------------------------
// color_palette_table_core - packed find-or-insert color table
// Keeps up to TABLE_SLOTS-1 colors in one RAM; a sequencer scans or shifts
// the entries one per cycle.
// ---------------------------------------------------------------------------
// Usage:
//   A request (cmd_i, color_i, slot_i) is taken on a clock edge with start_i
//   high and busy_o low. busy_o stays high while the request is worked on.
//   The result (slot_id_o, status_o, entry_count_o, version_o) is valid for
//   exactly one cycle while done_o is high; the receiver cannot stall it,
//   and a new request may be issued in that same cycle.
// Sequencing per command:
//   add, unknown command, refused set/remove: result registered from idle
//   set color: one RAM read, then compare and write
//   intern, find: the scan reads one RAM entry per cycle and stops at the
//   first match or after the last used entry
//   remove: one read and one write per entry moved down, through the
//   single RAM read port
// Reset clears the entry count and the version counter. The color RAM is
// not cleared; only entries below the entry count are ever read.
// ---------------------------------------------------------------------------
module color_palette_table_core
  import cpt_pkg::*;
#(
  parameter int unsigned TABLE_SLOTS = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [CmdW-1:0]    cmd_i,
  input  logic [ColorW-1:0]  color_i,
  input  logic [SlotW-1:0]   slot_i,
  output logic               done_o,
  output logic [SlotW-1:0]   slot_id_o,
  output logic [StatusW-1:0] status_o,
  output logic [SlotW-1:0]   entry_count_o,
  output logic [ColorW-1:0]  version_o
);

  localparam int unsigned AW = $clog2(TABLE_SLOTS);
  localparam logic [AW-1:0] LastSlot = AW'(TABLE_SLOTS - 1);

  // Sequencer states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_SETCMP = 2'd2;
  localparam logic [1:0] S_SHIFT  = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [CmdW-1:0]    cmd_q;
  logic [ColorW-1:0]  color_q;
  logic [AW-1:0]      slot_q;
  logic [AW-1:0]      rd_q, rd_d;
  logic               pend_q, pend_d;
  logic [AW-1:0]      pidx_q, pidx_d;
  logic [AW-1:0]      used_q, used_d;
  logic [ColorW-1:0]  version_q, version_d;
  logic               done_q, done_d;
  logic [SlotW-1:0]   slot_id_q, slot_id_d;
  logic [StatusW-1:0] status_q, status_d;

  logic [ColorW-1:0]  mem_q [TABLE_SLOTS];
  logic [ColorW-1:0]  rdata_q;
  logic               mem_re, mem_we;
  logic [AW-1:0]      mem_ra, mem_wa;
  logic [ColorW-1:0]  mem_wd;

  logic accept;
  logic full;
  logic hit;

  assign accept = start_i && (state_q == S_IDLE);
  assign full   = (used_q == LastSlot);
  assign hit    = pend_q && (rdata_q == color_q);

  // Sequencer next state and RAM control
  always_comb begin
    state_d   = state_q;
    rd_d      = rd_q;
    pend_d    = 1'b0;
    pidx_d    = pidx_q;
    used_d    = used_q;
    version_d = version_q;
    done_d    = 1'b0;
    slot_id_d = slot_id_q;
    status_d  = status_q;
    mem_re    = 1'b0;
    mem_ra    = rd_q;
    mem_we    = 1'b0;
    mem_wa    = used_q;
    mem_wd    = color_q;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (cmd_i)
            CMD_INTERN, CMD_FIND: begin
              rd_d    = '0;
              state_d = S_SCAN;
            end
            CMD_ADD: begin
              done_d = 1'b1;
              if (full) begin
                slot_id_d = NO_SLOT;
                status_d  = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_wd    = color_i;
                slot_id_d = SlotW'(used_q);
                status_d  = ST_OK;
                used_d    = used_q + 1'b1;
                version_d = version_q + 1'b1;
              end
            end
            CMD_SET: begin
              if (slot_i >= SlotW'(used_q)) begin
                done_d    = 1'b1;
                slot_id_d = NO_SLOT;
                status_d  = ST_BAD_SLOT;
              end else begin
                mem_re  = 1'b1;
                mem_ra  = slot_i[AW-1:0];
                state_d = S_SETCMP;
              end
            end
            CMD_REMOVE: begin
              if (slot_i >= SlotW'(used_q)) begin
                done_d    = 1'b1;
                slot_id_d = NO_SLOT;
                status_d  = ST_BAD_SLOT;
              end else if (used_q == AW'(1)) begin
                done_d    = 1'b1;
                slot_id_d = NO_SLOT;
                status_d  = ST_LAST;
              end else begin
                rd_d    = slot_i[AW-1:0] + 1'b1;
                state_d = S_SHIFT;
              end
            end
            default: begin
              done_d    = 1'b1;
              slot_id_d = NO_SLOT;
              status_d  = ST_OK;
            end
          endcase
        end
      end

      // Compare the entry read last cycle, issue the next read
      S_SCAN: begin
        if (hit) begin
          done_d    = 1'b1;
          slot_id_d = SlotW'(pidx_q);
          status_d  = ST_OK;
          state_d   = S_IDLE;
        end else if (rd_q != used_q) begin
          mem_re = 1'b1;
          rd_d   = rd_q + 1'b1;
          pend_d = 1'b1;
          pidx_d = rd_q;
        end else begin
          done_d  = 1'b1;
          state_d = S_IDLE;
          if (cmd_q == CMD_FIND) begin
            slot_id_d = NO_SLOT;
            status_d  = ST_NOT_FOUND;
          end else if (full) begin
            slot_id_d = NO_SLOT;
            status_d  = ST_FULL;
          end else begin
            mem_we    = 1'b1;
            slot_id_d = SlotW'(used_q);
            status_d  = ST_OK;
            used_d    = used_q + 1'b1;
            version_d = version_q + 1'b1;
          end
        end
      end

      // Overwrite the slot only when the color really differs
      S_SETCMP: begin
        done_d    = 1'b1;
        slot_id_d = SlotW'(slot_q);
        status_d  = ST_OK;
        state_d   = S_IDLE;
        if (rdata_q != color_q) begin
          mem_we    = 1'b1;
          mem_wa    = slot_q;
          version_d = version_q + 1'b1;
        end
      end

      // Move each entry above the removed slot down by one
      S_SHIFT: begin
        if (pend_q) begin
          mem_we = 1'b1;
          mem_wa = pidx_q - 1'b1;
          mem_wd = rdata_q;
        end
        if (rd_q != used_q) begin
          mem_re = 1'b1;
          rd_d   = rd_q + 1'b1;
          pend_d = 1'b1;
          pidx_d = rd_q;
        end else begin
          done_d    = 1'b1;
          slot_id_d = SlotW'(slot_q);
          status_d  = ST_OK;
          used_d    = used_q - 1'b1;
          version_d = version_q + 1'b1;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control and counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rd_q      <= '0;
      pend_q    <= 1'b0;
      pidx_q    <= '0;
      used_q    <= '0;
      version_q <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_q      <= rd_d;
      pend_q    <= pend_d;
      pidx_q    <= pidx_d;
      used_q    <= used_d;
      version_q <= version_d;
      done_q    <= done_d;
    end
  end

  // Hold the request and the result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_i;
      color_q <= color_i;
      slot_q  <= slot_i[AW-1:0];
    end
    slot_id_q <= slot_id_d;
    status_q  <= status_d;
  end

  // Color RAM: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_ra];
    end
  end

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign slot_id_o     = slot_id_q;
  assign status_o      = status_q;
  assign entry_count_o = SlotW'(used_q);
  assign version_o     = version_q;

endmodule

### src/cpt_checker.sv
// ---------------------------------------------------------------------------
// cpt_checker - port-level checks for color_palette_table_core
// Watches the request and result ports and flags sequencing slips.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cpt_checker
  import cpt_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               done_o,
  input logic [SlotW-1:0]   slot_id_o,
  input logic [StatusW-1:0] status_o,
  input logic [SlotW-1:0]   entry_count_o,
  input logic [ColorW-1:0]  version_o
);

  // A taken request either finishes at once or keeps the block busy
  property p_start_progress;
    (start_i && !busy_o) |=> (busy_o || done_o);
  endproperty

  // Table state moves only together with a result
  property p_state_quiet;
    !done_o |-> ($stable(version_o) && $stable(entry_count_o));
  endproperty

  // A refused request reports no slot and leaves the table alone
  property p_refuse_clean;
    (done_o && status_o != ST_OK) |->
      (slot_id_o == NO_SLOT && $stable(version_o) && $stable(entry_count_o));
  endproperty

  `ASSERT_CLK_RST(a_start_progress, clk_i, rst_ni, p_start_progress, "request neither busy nor done")

  `ASSERT_CLK_RST(a_state_quiet, clk_i, rst_ni, p_state_quiet, "table changed without a result")

  `ASSERT_CLK_RST(a_refuse_clean, clk_i, rst_ni, p_refuse_clean, "refused request changed state")

  // The result cycle is never a busy cycle
  `ASSERT_CLK_RST(a_done_idle, clk_i, rst_ni, done_o |-> !busy_o, "result while busy")

endmodule

bind color_palette_table_core cpt_checker u_cpt_checker (.*);

### tb/sv/color_palette_table_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// color_palette_table_core_tb - self-checking bench for the color table
// Feeds intern, add, find, set, remove and unknown-code requests through
// the start/busy handshake, with random gaps and noise on idle inputs.
// Every accepted request is run through a local table predictor. Each done
// strobe is checked field by field against the oldest prediction. The
// random part fills the table to its limit and drains it to one entry.
// ---------------------------------------------------------------------------
module color_palette_table_core_tb;
  import cpt_pkg::*;

  localparam int unsigned TableSlots    = 256;
  localparam int unsigned MaxGap        = 19;
  localparam int unsigned RandomReqs    = 1750;
  localparam int unsigned FullHoldReqs  = 25;
  localparam int unsigned DrainCycles   = 300;
  localparam longint unsigned CycleLimit = 2_500_000;

  // Command codes with no function; the core must ignore them
  localparam logic [CmdW-1:0] CmdUnknownLo = 3'd5;
  localparam logic [CmdW-1:0] CmdUnknownHi = 3'd7;

  typedef struct {
    logic [CmdW-1:0]   cmd;
    logic [ColorW-1:0] color;
    logic [SlotW-1:0]  slot;
    int unsigned       gap;
  } palette_req_t;

  typedef struct {
    logic [SlotW-1:0]   slot_id;
    logic [StatusW-1:0] status;
    logic [SlotW-1:0]   entry_count;
    logic [ColorW-1:0]  version;
  } palette_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic [CmdW-1:0]    cmd_i = '0;
  logic [ColorW-1:0]  color_i = '0;
  logic [SlotW-1:0]   slot_i = '0;
  logic               busy_o;
  logic               done_o;
  logic [SlotW-1:0]   slot_id_o;
  logic [StatusW-1:0] status_o;
  logic [SlotW-1:0]   entry_count_o;
  logic [ColorW-1:0]  version_o;

  color_palette_table_core #(
    .TABLE_SLOTS(TableSlots)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .cmd_i        (cmd_i),
    .color_i      (color_i),
    .slot_i       (slot_i),
    .done_o       (done_o),
    .slot_id_o    (slot_id_o),
    .status_o     (status_o),
    .entry_count_o(entry_count_o),
    .version_o    (version_o)
  );

  // Predicted table contents
  logic [ColorW-1:0] palette_colors [TableSlots];
  int unsigned       palette_used = 0;
  logic [ColorW-1:0] palette_version = '0;

  palette_req_t      pending_reqs[$];
  palette_result_t   expected_results[$];
  logic [ColorW-1:0] color_pool [16];

  bit           req_taken = 1'b0;
  bit           have_next = 1'b0;
  palette_req_t next_req;
  int unsigned  wait_left = 0;
  int unsigned  calm_left = 0;

  int unsigned     fail_count = 0;
  int unsigned     accepted_count = 0;
  int unsigned     checked_count = 0;
  int unsigned     peak_used = 0;
  int unsigned     status_seen [5] = '{default: 0};
  longint unsigned cycle_count = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Lowest slot holding the color, or NO_SLOT
  function automatic int unsigned lowest_match(logic [ColorW-1:0] color);
    for (int unsigned i = 0; i < palette_used; i++) begin
      if (palette_colors[i] == color) return i;
    end
    return NO_SLOT;
  endfunction

  // Apply one request to the predicted table and return its result
  function automatic palette_result_t predict_palette(palette_req_t req);
    palette_result_t res;
    int unsigned hit;
    res.slot_id = NO_SLOT;
    res.status  = ST_OK;
    case (req.cmd)
      CMD_INTERN, CMD_ADD: begin
        hit = (req.cmd == CMD_INTERN) ? lowest_match(req.color) : NO_SLOT;
        if (hit != NO_SLOT) begin
          res.slot_id = SlotW'(hit);
        end else if (palette_used >= TableSlots - 1) begin
          res.status = ST_FULL;
        end else begin
          palette_colors[palette_used] = req.color;
          res.slot_id = SlotW'(palette_used);
          palette_used++;
          palette_version++;
        end
      end
      CMD_FIND: begin
        hit = lowest_match(req.color);
        res.slot_id = SlotW'(hit);
        if (hit == NO_SLOT) res.status = ST_NOT_FOUND;
      end
      CMD_SET: begin
        if (req.slot >= palette_used) begin
          res.status = ST_BAD_SLOT;
        end else begin
          res.slot_id = req.slot;
          if (palette_colors[req.slot] != req.color) begin
            palette_colors[req.slot] = req.color;
            palette_version++;
          end
        end
      end
      CMD_REMOVE: begin
        if (req.slot >= palette_used) begin
          res.status = ST_BAD_SLOT;
        end else if (palette_used == 1) begin
          res.status = ST_LAST;
        end else begin
          // shift every entry above the removed slot down by one
          for (int unsigned i = req.slot; i + 1 < palette_used; i++) begin
            palette_colors[i] = palette_colors[i + 1];
          end
          palette_used--;
          palette_version++;
          res.slot_id = req.slot;
        end
      end
      default: ;
    endcase
    res.entry_count = SlotW'(palette_used);
    res.version     = palette_version;
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Mix of repeated palette colors, colors already stored, and fresh words
  function automatic logic [ColorW-1:0] pick_color();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return color_pool[$urandom_range(0, 15)];
    if (r < 6 && palette_used > 0) return palette_colors[$urandom_range(0, palette_used - 1)];
    return $urandom();
  endfunction

  // Mostly valid slots, the rest at or past the entry count
  function automatic logic [SlotW-1:0] pick_slot();
    if (palette_used > 0 && $urandom_range(0, 9) < 8)
      return SlotW'($urandom_range(0, palette_used - 1));
    return SlotW'($urandom_range(palette_used, 255));
  endfunction

  // Queue one request, keeping only a short backlog so choices track the table
  task automatic queue_req(logic [CmdW-1:0] cmd, logic [ColorW-1:0] color,
                           logic [SlotW-1:0] slot);
    palette_req_t req;
    req.cmd   = cmd;
    req.color = color;
    req.slot  = slot;
    if (calm_left > 0) begin
      calm_left--;
      req.gap = 0;
    end else begin
      req.gap = $urandom_range(0, MaxGap);
      if ($urandom_range(0, 99) == 0) calm_left = $urandom_range(20, 60);
    end
    while (pending_reqs.size() >= 2) @(posedge clk_i);
    pending_reqs.insert(pending_reqs.size(), req);
  endtask

  // Driver: issue requests at the falling edge, hold each until taken
  always @(negedge clk_i) begin
    if (rst_ni && (!start_i || req_taken)) begin
      if (wait_left > 0) begin
        wait_left--;
        start_i <= 1'b0;
        cmd_i   <= CmdW'($urandom_range(0, 7));
        color_i <= $urandom();
        slot_i  <= SlotW'($urandom_range(0, 255));
      end else if (have_next || pending_reqs.size() > 0) begin
        if (!have_next) begin
          next_req  = pending_reqs.pop_front();
          have_next = 1'b1;
          wait_left = next_req.gap;
        end
        if (wait_left > 0) begin
          // idle before this request, with noise on the payload
          wait_left--;
          start_i <= 1'b0;
          cmd_i   <= CmdW'($urandom_range(0, 7));
          color_i <= $urandom();
          slot_i  <= SlotW'($urandom_range(0, 255));
        end else begin
          have_next = 1'b0;
          start_i <= 1'b1;
          cmd_i   <= next_req.cmd;
          color_i <= next_req.color;
          slot_i  <= next_req.slot;
        end
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: check results first, then record a newly taken request
  always @(posedge clk_i) begin
    palette_result_t want;
    palette_req_t    seen;
    if (rst_ni) begin
      if (done_o) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected, slot_id %0d status %0d", $time,
                   slot_id_o, status_o);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("slot_id", want.slot_id, slot_id_o);
          check_field("status", want.status, status_o);
          check_field("entry_count", want.entry_count, entry_count_o);
          check_field("version", want.version, version_o);
          checked_count++;
        end
      end
      req_taken = start_i && !busy_o;
      if (req_taken) begin
        seen.cmd   = cmd_i;
        seen.color = color_i;
        seen.slot  = slot_i;
        seen.gap   = 0;
        want = predict_palette(seen);
        expected_results.insert(expected_results.size(), want);
        accepted_count++;
        if (want.status <= ST_NOT_FOUND) status_seen[want.status]++;
        if (palette_used > peak_used) peak_used = palette_used;
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int unsigned r;
    int unsigned full_reqs;
    bit          growing;
    logic [CmdW-1:0] cmd;

    color_pool[0] = 32'h0000_0000;
    color_pool[1] = 32'hFFFF_FFFF;
    color_pool[2] = 32'h8000_0000;
    color_pool[3] = 32'h0000_0001;
    for (int i = 4; i < 16; i++) color_pool[i] = $urandom();

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty table, single entry, duplicates, shifts, ignored codes
    queue_req(CMD_FIND, 32'h0000_0000, 8'd0);
    queue_req(CMD_REMOVE, 32'h0000_0000, 8'd0);
    queue_req(CMD_SET, 32'hFFFF_FFFF, 8'd0);
    queue_req(CMD_INTERN, 32'h0000_0000, 8'd255);
    queue_req(CMD_REMOVE, 32'hFFFF_FFFF, 8'd0);
    queue_req(CMD_INTERN, 32'hFFFF_FFFF, 8'd0);
    queue_req(CMD_INTERN, 32'h0000_0000, 8'd0);
    queue_req(CMD_ADD, 32'h0000_0000, 8'd255);
    queue_req(CMD_INTERN, 32'h0000_0000, 8'd0);
    queue_req(CMD_FIND, 32'hFFFF_FFFF, 8'd0);
    queue_req(CMD_FIND, 32'h1234_5678, 8'd0);
    queue_req(CMD_SET, 32'hFFFF_FFFF, 8'd1);
    queue_req(CMD_SET, 32'hA5A5_A5A5, 8'd2);
    queue_req(CMD_SET, 32'h5A5A_5A5A, 8'd3);
    queue_req(CMD_SET, 32'h5A5A_5A5A, 8'd255);
    queue_req(CMD_REMOVE, 32'h0000_0000, 8'd255);
    queue_req(CMD_REMOVE, 32'h0000_0000, 8'd0);
    queue_req(CMD_FIND, 32'hA5A5_A5A5, 8'd0);
    queue_req(CmdUnknownLo, 32'hFFFF_FFFF, 8'd255);
    queue_req(CmdUnknownLo + 3'd1, 32'h0000_0000, 8'd0);
    queue_req(CmdUnknownHi, 32'hFFFF_FFFF, 8'd255);
    queue_req(CMD_REMOVE, 32'h0000_0000, 8'd1);
    queue_req(CMD_ADD, 32'h5A5A_5A5A, 8'd0);

    // Random: alternate growing to the full limit and draining to one entry
    growing   = 1'b1;
    full_reqs = 0;
    for (int unsigned n = 0; n < RandomReqs; n++) begin
      if (palette_used >= TableSlots - 1) full_reqs++;
      if (growing && full_reqs >= FullHoldReqs) begin
        growing   = 1'b0;
        full_reqs = 0;
      end else if (!growing && palette_used <= 1) begin
        growing = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (growing) begin
        if (r < 40)      cmd = CMD_ADD;
        else if (r < 60) cmd = CMD_INTERN;
        else if (r < 70) cmd = CMD_FIND;
        else if (r < 85) cmd = CMD_SET;
        else if (r < 93) cmd = CMD_REMOVE;
        else if (r < 96) cmd = CmdW'($urandom_range(CmdUnknownLo, CmdUnknownHi));
        else             cmd = CMD_INTERN;
      end else begin
        if (r < 60)      cmd = CMD_REMOVE;
        else if (r < 70) cmd = CMD_INTERN;
        else if (r < 80) cmd = CMD_FIND;
        else if (r < 90) cmd = CMD_SET;
        else if (r < 95) cmd = CMD_ADD;
        else             cmd = CmdW'($urandom_range(CmdUnknownLo, CmdUnknownHi));
      end
      // a full table only refuses colors it does not already hold
      if (palette_used >= TableSlots - 1 && cmd == CMD_INTERN && r[0])
        queue_req(cmd, $urandom(), pick_slot());
      else
        queue_req(cmd, pick_color(), pick_slot());
    end

    // Drain: let the last request go out, then collect every result
    while (pending_reqs.size() > 0 || have_next || start_i) @(posedge clk_i);
    while (expected_results.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("requests %0d, results checked %0d, peak entry count %0d",
             accepted_count, checked_count, peak_used);
    $display("status mix: ok %0d, full %0d, bad slot %0d, last entry %0d, not found %0d",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_BAD_SLOT],
             status_seen[ST_LAST], status_seen[ST_NOT_FOUND]);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
